@@ hdl/hggv_pkg.sv @@
`default_nettype none
package hggv_pkg;
   localparam int POS_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int TAB_LEN           = 24;
   localparam int CFG_IDX_W         = 3;
   localparam int CFG_DATA_W        = 16;
   localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN     = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_YAW   = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_DIV   = 3'd7;
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_DONE   = 2'd2;
   localparam logic [15:0] INV_GAIN = 16'd39797;

   typedef struct packed {
      logic        new_target;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [31:0] gaze_x;
      logic signed [31:0] gaze_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] yaw_rate;
   } req_type;

   typedef struct packed {
      logic        cmd_valid;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_yaw;
      logic [31:0] dist_twice;
      logic [1:0]  mode;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic rotate;
   } cordic_ctl_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;  5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;  5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;   5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;   5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;    5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
         5'd20: r = 32'd652;        5'd21: r = 32'd326;
         5'd22: r = 32'd163;        5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ hdl/hggv_if.sv @@
`default_nettype none
interface hggv_req_if;
   import hggv_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hggv_rsp_if;
   import hggv_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/hggv_cordic.sv @@
`default_nettype none
module hggv_cordic #(
   parameter int CORDIC_STEPS = hggv_pkg::CORDIC_STEPS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  hggv_pkg::cordic_ctl_type ctl,
   input  wire  signed [39:0]    x_init,
   input  wire  signed [39:0]    y_init,
   input  wire         [31:0]    z_init,
   output logic                  busy,
   output logic signed [39:0]    x_out,
   output logic signed [39:0]    y_out,
   output logic        [31:0]    z_out
);
   import hggv_pkg::*;
   localparam int STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

   logic signed [39:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in, rot_ff, rot_in;
   logic        dir;
   logic signed [39:0] dx, dy;
   logic signed [32:0] zs;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; rot_in = rot_ff;
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      dir = rot_ff ? !z_ff[31] : (y_ff > 40'sd0);
      zs = 33'sd0;
      if (ctl.start) begin
         rot_in = ctl.rotate; step_in = 5'd0; busy_in = 1'b1;
         x_in = x_init; y_in = y_init; z_in = z_init;
         if (ctl.rotate) begin
            zs = $signed({z_init[31], z_init});
            if (zs > 33'sd1073741824) begin
               x_in = -x_init; z_in = z_init + 32'h80000000;
            end else if (zs < -33'sd1073741824) begin
               x_in = -x_init; z_in = z_init + 32'h80000000;
            end
         end else begin
            if (x_init == 40'sd0 && y_init == 40'sd0) begin
               busy_in = 1'b0; z_in = 32'd0;
            end else if (x_init < 40'sd0) begin
               x_in = -x_init; y_in = -y_init; z_in = 32'h80000000;
            end else begin
               z_in = 32'd0;
            end
         end
      end else if (busy_ff) begin
         if (dir) begin
            x_in = rot_ff ? x_ff - dx : x_ff + dx;
            y_in = rot_ff ? y_ff + dy : y_ff - dy;
            z_in = rot_ff ? z_ff - atan_entry(step_ff) : z_ff + atan_entry(step_ff);
         end else begin
            x_in = rot_ff ? x_ff + dx : x_ff - dx;
            y_in = rot_ff ? y_ff - dy : y_ff + dy;
            z_in = rot_ff ? z_ff + atan_entry(step_ff) : z_ff - atan_entry(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; step_ff <= 5'd0; rot_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; step_ff <= step_in; rot_ff <= rot_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   assign busy  = busy_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

@@ hdl/hggv_divider.sv @@
`default_nettype none
module hggv_divider (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire  signed [31:0] num,
   input  wire         [7:0]  den,
   output logic               busy,
   output logic signed [31:0] quo
);
   logic [31:0] rem_ff, rem_in, q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [7:0]  den_ff, den_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; den_in = den_ff;
      trial = {rem_ff, q_ff[31]} - {25'd0, den_ff};
      if (start) begin
         neg_in = num[31];
         q_in = num[31] ? 32'(-num) : 32'(num);
         rem_in = 32'd0; cnt_in = 6'd0; busy_in = 1'b1;
         den_in = (den == 8'd0) ? 8'd1 : den;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0]; q_in = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], q_ff[31]}; q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; neg_ff <= neg_in; den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule
`default_nettype wire

@@ hdl/holonomic_goal_gaze_velocity_ctrl.sv @@
// An active request runs the heading, goal, gaze and rotate CORDIC passes and then the x
// and y divides; a zero goal or gaze vector skips that CORDIC pass's iterations.
// Throughput: one tick at a time; idle or done ticks skip the CORDIC and the divider, and
// active ticks are paced by the shared CORDIC and the serial divider.
// req ready is low from acceptance until the response beat is taken.
// Synchronous active-high reset restores register defaults, idle mode and zero state.
`default_nettype none
module holonomic_goal_gaze_velocity_ctrl #(
   parameter int POS_FRAC_BITS = hggv_pkg::POS_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS  = hggv_pkg::CORDIC_STEPS_DEF
) (
   input  wire clock,
   input  wire reset,
   hggv_req_if.sink   req,
   hggv_rsp_if.source rsp,
   input  wire                                   csr_we,
   input  wire [hggv_pkg::CFG_IDX_W-1:0]         csr_index,
   input  wire [hggv_pkg::CFG_DATA_W-1:0]        csr_data
);
   import hggv_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0,  S_HEAD = 5'd1,  S_HEADW = 5'd2,
                          S_GOAL = 5'd3,  S_GOALW = 5'd4, S_GAZE = 5'd5,
                          S_GAZEW = 5'd6, S_MUL1 = 5'd7,  S_MUL2 = 5'd8,
                          S_MUL3 = 5'd9,  S_ROT = 5'd10,  S_ROTW = 5'd11,
                          S_DIVX = 5'd12, S_DIVXW = 5'd13, S_DIVY = 5'd14,
                          S_DIVYW = 5'd15, S_FIN = 5'd16, S_OUT = 5'd17;

   logic [14:0] speed_limit_ff, yaw_limit_ff, yaw_deadband_ff, arrive_yaw_ff;
   logic [11:0] yaw_gain_ff;
   logic [15:0] arrive_dist_ff, hold_ticks_ff, hold_count_ff, hold_count_in;
   logic [7:0]  smooth_div_ff;
   logic [1:0]  run_mode_ff, run_mode_in;
   logic        arrived_ff, arrived_in;
   logic signed [15:0] last_x_ff, last_x_in, last_y_ff, last_y_in, last_yaw_ff, last_yaw_in;
   logic [4:0]  state_ff, state_in;
   req_type     r_ff, r_in;
   rsp_type     o_ff, o_in;
   logic [31:0] yaw_ff, yaw_in, ta_ff, ta_in, err_ff, err_in;
   logic signed [39:0] dmag_ff, dmag_in;
   logic [33:0] dist2_ff, dist2_in;
   logic [63:0] prod_ff, prod_in;
   logic signed [16:0] yv_ff, yv_in;
   logic [15:0] sc_ff, sc_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] nx_ff, nx_in;

   cordic_ctl_type cctl;
   logic signed [39:0] cx0, cy0, cxo, cyo;
   logic [31:0] cz0, czo;
   logic        cbusy, dstart, dbusy;
   logic signed [31:0] dnum, dquo;

   hggv_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .ctl(cctl), .x_init(cx0), .y_init(cy0), .z_init(cz0),
      .busy(cbusy), .x_out(cxo), .y_out(cyo), .z_out(czo));

   hggv_divider u_div (
      .clock, .reset, .start(dstart), .num(dnum), .den(smooth_div_ff),
      .busy(dbusy), .quo(dquo));

   logic signed [31:0] qq;
   logic [31:0] emag, ydel;
   logic [32:0] e1;
   logic signed [31:0] nsat;
   logic signed [47:0] wprod;
   logic [47:0] scl;
   logic signed [39:0] rotmag;
   logic hit;

   always_comb begin
      state_in = state_ff; r_in = r_ff; o_in = o_ff;
      yaw_in = yaw_ff; ta_in = ta_ff; err_in = err_ff; dmag_in = dmag_ff;
      dist2_in = dist2_ff; prod_in = prod_ff; yv_in = yv_ff; sc_in = sc_ff;
      cx_in = cx_ff; cy_in = cy_ff; nx_in = nx_ff;
      run_mode_in = run_mode_ff; arrived_in = arrived_ff; hold_count_in = hold_count_ff;
      last_x_in = last_x_ff; last_y_in = last_y_ff; last_yaw_in = last_yaw_ff;
      cctl = '0; cx0 = '0; cy0 = '0; cz0 = '0; dstart = 1'b0; dnum = '0;
      qq = 32'(r_ff.quat_z) * 32'(r_ff.quat_w);
      emag = err_ff[31] ? 32'(-err_ff) : err_ff;
      e1 = '0; nsat = '0; hit = 1'b0;
      wprod = 48'(r_ff.yaw_rate) * 48'sd320421;
      ydel = 32'(wprod >>> 6);
      scl = (POS_FRAC_BITS >= 15) ? 48'(dist2_ff >> (POS_FRAC_BITS - 15))
                                  : 48'(dist2_ff) << (15 - POS_FRAC_BITS);
      rotmag = $signed(({24'd0, sc_ff} * {24'd0, INV_GAIN}) >> 1);
      case (state_ff)
         S_IDLE: if (req.valid) begin
            r_in = req.data;
            if (req.data.new_target) begin
               run_mode_in = MODE_ACTIVE; arrived_in = 1'b0;
            end
            if (req.data.new_target || run_mode_ff == MODE_ACTIVE) state_in = S_HEAD;
            else begin
               o_in = '0; o_in.mode = run_mode_ff; state_in = S_OUT;
            end
         end
         S_HEAD: begin
            cctl.start = 1'b1;
            cx0 = 40'sd268435456 - 40'(32'(r_ff.quat_z) * 32'(r_ff.quat_z)) * 2;
            cy0 = 40'(qq) * 2;
            state_in = S_HEADW;
         end
         S_HEADW: if (!cbusy) begin
            yaw_in = czo; state_in = S_GOAL;
         end
         S_GOAL: begin
            cctl.start = 1'b1;
            cx0 = 40'(r_ff.goal_x) - 40'(r_ff.pos_x);
            cy0 = 40'(r_ff.goal_y) - 40'(r_ff.pos_y);
            state_in = S_GOALW;
         end
         S_GOALW: if (!cbusy) begin
            ta_in = czo; dmag_in = cxo; state_in = S_GAZE;
         end
         S_GAZE: begin
            cctl.start = 1'b1;
            cx0 = 40'(r_ff.gaze_x) - 40'(r_ff.pos_x);
            cy0 = 40'(r_ff.gaze_y) - 40'(r_ff.pos_y);
            prod_in = 64'(dmag_ff[33:0]) * 64'(INV_GAIN);
            state_in = S_GAZEW;
         end
         S_GAZEW: if (!cbusy) begin
            err_in = czo - yaw_ff;
            dist2_in = {prod_ff[48:16], 1'b0};
            state_in = S_MUL1;
         end
         S_MUL1: begin
            prod_in = (64'(emag) * 64'd205887) >> 32;
            sc_in = (scl > 48'(speed_limit_ff)) ? {1'b0, speed_limit_ff} : scl[15:0];
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in = 64'(({12'd0, prod_ff[16:0]} * {17'd0, yaw_gain_ff}) >> 8);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            e1 = (prod_ff > 64'(yaw_limit_ff)) ? 33'(yaw_limit_ff) : prod_ff[32:0];
            if (e1 < 33'(yaw_deadband_ff)) e1 = '0;
            else if (e1 > 33'(yaw_deadband_ff)) e1 = e1 - 33'(yaw_deadband_ff);
            yv_in = err_ff[31] ? -17'(e1) : 17'(e1);
            state_in = S_ROT;
         end
         S_ROT: begin
            cctl.start = 1'b1; cctl.rotate = 1'b1;
            cx0 = rotmag; cz0 = ta_ff - (yaw_ff + ydel);
            state_in = S_ROTW;
         end
         S_ROTW: if (!cbusy) begin
            cx_in = 32'(cxo >>> 16); cy_in = 32'(cyo >>> 16); state_in = S_DIVX;
         end
         S_DIVX: begin
            dstart = 1'b1; dnum = cx_ff - 32'(last_x_ff); state_in = S_DIVXW;
         end
         S_DIVXW: if (!dbusy) begin
            nx_in = 32'(last_x_ff) + dquo; state_in = S_DIVY;
         end
         S_DIVY: begin
            dstart = 1'b1; dnum = cy_ff - 32'(last_y_ff); state_in = S_DIVYW;
         end
         S_DIVYW: if (!dbusy) begin
            cy_in = 32'(last_y_ff) + dquo; state_in = S_FIN;
         end
         S_FIN: begin
            o_in.cmd_valid = 1'b1;
            o_in.dist_twice = (|dist2_ff[33:32]) ? 32'hFFFFFFFF : dist2_ff[31:0];
            nsat = (nx_ff > 32'sd32767) ? 32'sd32767 :
                   (nx_ff < -32'sd32768) ? -32'sd32768 : nx_ff;
            o_in.vel_x = nsat[15:0];
            nsat = (cy_ff > 32'sd32767) ? 32'sd32767 :
                   (cy_ff < -32'sd32768) ? -32'sd32768 : cy_ff;
            o_in.vel_y = nsat[15:0];
            o_in.vel_yaw = yv_ff[15:0];
            hold_count_in = hold_count_ff;
            if (arrived_ff && hold_count_ff != 16'hFFFF) hold_count_in = hold_count_ff + 16'd1;
            arrived_in = arrived_ff;
            if (o_in.dist_twice < 32'(arrive_dist_ff)
                && (yv_ff[16] ? -yv_ff : yv_ff) < $signed({2'b0, arrive_yaw_ff})
                && !arrived_ff) begin
               arrived_in = 1'b1; hold_count_in = 16'd0;
            end
            hit = arrived_in && hold_count_in >= hold_ticks_ff;
            if (hit) begin
               arrived_in = 1'b0; run_mode_in = MODE_DONE;
               o_in.vel_x = '0; o_in.vel_y = '0; o_in.vel_yaw = '0;
            end
            o_in.mode = hit ? MODE_DONE : run_mode_ff;
            last_x_in = o_in.vel_x; last_y_in = o_in.vel_y; last_yaw_in = o_in.vel_yaw;
            state_in = S_OUT;
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; run_mode_ff <= MODE_IDLE; arrived_ff <= 1'b0;
         hold_count_ff <= '0; last_x_ff <= '0; last_y_ff <= '0; last_yaw_ff <= '0;
         speed_limit_ff <= 15'd13107; yaw_gain_ff <= 12'd1536;
         yaw_limit_ff <= 15'd13107; yaw_deadband_ff <= 15'd1638;
         arrive_dist_ff <= 16'd3277; arrive_yaw_ff <= 15'd2621;
         hold_ticks_ff <= 16'd500; smooth_div_ff <= 8'd50;
      end else begin
         state_ff <= state_in; run_mode_ff <= run_mode_in; arrived_ff <= arrived_in;
         hold_count_ff <= hold_count_in;
         last_x_ff <= last_x_in; last_y_ff <= last_y_in; last_yaw_ff <= last_yaw_in;
         if (csr_we) begin
            case (csr_index)
               REG_SPEED_LIMIT:  speed_limit_ff  <= csr_data[14:0];
               REG_YAW_GAIN:     yaw_gain_ff     <= csr_data[11:0];
               REG_YAW_LIMIT:    yaw_limit_ff    <= csr_data[14:0];
               REG_YAW_DEADBAND: yaw_deadband_ff <= csr_data[14:0];
               REG_ARRIVE_DIST:  arrive_dist_ff  <= csr_data;
               REG_ARRIVE_YAW:   arrive_yaw_ff   <= csr_data[14:0];
               REG_HOLD_TICKS:   hold_ticks_ff   <= csr_data;
               REG_SMOOTH_DIV:   smooth_div_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      r_ff <= r_in; o_ff <= o_in; yaw_ff <= yaw_in; ta_ff <= ta_in; err_ff <= err_in;
      dmag_ff <= dmag_in; dist2_ff <= dist2_in; prod_ff <= prod_in; yv_ff <= yv_in;
      sc_ff <= sc_in; cx_ff <= cx_in; cy_ff <= cy_in; nx_ff <= nx_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = o_ff;
endmodule
`default_nettype wire

@@ hdl/hggv_checker.sv @@
`default_nettype none
module hggv_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire [1:0] rsp_mode,
   input wire rsp_cmd_valid,
   input wire [15:0] rsp_vel_x
);
   import hggv_pkg::*;
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_valid |-> rsp_mode != MODE_IDLE) else $error("cmd in idle");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cmd_valid |-> rsp_vel_x == 16'd0) else $error("velocity when idle");
endmodule

bind holonomic_goal_gaze_velocity_ctrl hggv_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_mode(rsp.data.mode),
   .rsp_cmd_valid(rsp.data.cmd_valid), .rsp_vel_x(rsp.data.vel_x));
`default_nettype wire

@@ tb/sv/holonomic_goal_gaze_velocity_ctrl_tb.sv @@
`timescale 1ns / 1ps
module holonomic_goal_gaze_velocity_ctrl_tb;
   import hggv_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1830;
   localparam int PHASES = 5;

   typedef struct {
      req_type data;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_DATA_W-1:0] csr_data;

   hggv_req_if req_ch ();
   hggv_rsp_if rsp_ch ();

   holonomic_goal_gaze_velocity_ctrl dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   bit [31:0] arc_tab [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
      32'd166886, 32'd83443, 32'd41722, 32'd20861
   };

   // controller copy
   longint speed_lim, gain, yaw_lim, deadband, arr_dist, arr_yaw, hold_lim, smooth;
   logic [1:0] run_state;
   bit     arrived;
   longint hold_cnt, prev_vx, prev_vy;

   rsp_type velocity_q [$];
   int     cycles;
   int     mismatches;
   int     burst_left;
   int     stall_left;
   bit     stall_random;

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit [31:0] vector_angle(longint x, longint y, output longint mag);
      bit [31:0] a;
      longint dx, dy;
      a = 0;
      mag = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; a = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; a += arc_tab[i];
         end else begin
            x -= dx; y += dy; a -= arc_tab[i];
         end
      end
      mag = x;
      return a;
   endfunction

   function automatic void rotate_vec(longint m, bit [31:0] ang, output longint c,
                                      output longint s);
      longint z, x, y, nx, ny;
      z = longint'(signed'(ang));
      x = m;
      y = 0;
      if (z > 64'sd1073741824) begin
         x = -x; z -= 64'sd2147483648;
      end else if (z < -64'sd1073741824) begin
         x = -x; z += 64'sd2147483648;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_tab[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arc_tab[i];
         end
         x = nx; y = ny;
      end
      c = x; s = y;
   endfunction

   function automatic rsp_type predict_velocity(req_type r);
      rsp_type o;
      longint gx, gy, zx, zy, px, py, qz, qw, wr, mag, dmag, d, dist2, gd;
      longint e, yv, sc, c, s, nx, ny, div;
      bit [31:0] head, ta, ga, err, emag, head_p;
      bit neg;
      o = '0;
      if (r.new_target) begin
         run_state = MODE_ACTIVE;
         arrived = 0;
      end
      if (run_state != MODE_ACTIVE) begin
         o.mode = run_state;
         return o;
      end
      gx = r.goal_x; gy = r.goal_y; zx = r.gaze_x; zy = r.gaze_y;
      px = r.pos_x; py = r.pos_y; qz = r.quat_z; qw = r.quat_w; wr = r.yaw_rate;
      head = vector_angle(64'sd268435456 - 2 * qz * qz, 2 * qz * qw, mag);
      ta = vector_angle(gx - px, gy - py, dmag);
      d = (dmag * 39797) >>> 16;
      dist2 = d * 2;
      gd = dist2 > 64'sh0_FFFF_FFFF ? 64'sh0_FFFF_FFFF : dist2;
      ga = vector_angle(zx - px, zy - py, mag);
      err = ga - head;
      neg = err[31];
      emag = neg ? -err : err;
      e = (longint'(emag) * 205887) >> 32;
      e = (e * gain) >> 8;
      if (e > yaw_lim) e = yaw_lim;
      if (e < deadband) e = 0;
      else if (e > deadband) e -= deadband;
      yv = neg ? -e : e;
      sc = dist2 >> 1;
      if (sc > speed_lim) sc = speed_lim;
      head_p = head + 32'((wr * 320421) >>> 6);
      rotate_vec((sc * 39797) >>> 1, ta - head_p, c, s);
      c = c >>> 16;
      s = s >>> 16;
      div = smooth == 0 ? 1 : smooth;
      nx = prev_vx + (c - prev_vx) / div;
      ny = prev_vy + (s - prev_vy) / div;
      if (nx > 32767) nx = 32767;
      if (nx < -32768) nx = -32768;
      if (ny > 32767) ny = 32767;
      if (ny < -32768) ny = -32768;
      if (arrived && hold_cnt < 65535) hold_cnt++;
      if (gd < arr_dist && (yv < 0 ? -yv : yv) < arr_yaw && !arrived) begin
         arrived = 1;
         hold_cnt = 0;
      end
      if (arrived && hold_cnt >= hold_lim) begin
         arrived = 0;
         run_state = MODE_DONE;
         nx = 0; ny = 0; yv = 0;
      end
      prev_vx = nx;
      prev_vy = ny;
      o.cmd_valid = 1'b1;
      o.vel_x = 16'(nx);
      o.vel_y = 16'(ny);
      o.vel_yaw = 16'(yv);
      o.dist_twice = 32'(gd);
      o.mode = run_state;
      return o;
   endfunction

   task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(value);
      @(posedge clock);
      case (idx)
         REG_SPEED_LIMIT:  speed_lim = value & 16'h7FFF;
         REG_YAW_GAIN:     gain = value & 16'h0FFF;
         REG_YAW_LIMIT:    yaw_lim = value & 16'h7FFF;
         REG_YAW_DEADBAND: deadband = value & 16'h7FFF;
         REG_ARRIVE_DIST:  arr_dist = value & 16'hFFFF;
         REG_ARRIVE_YAW:   arr_yaw = value & 16'h7FFF;
         REG_HOLD_TICKS:   hold_lim = value & 16'hFFFF;
         REG_SMOOTH_DIV:   smooth = value & 16'h00FF;
         default: ;
      endcase
   endtask

   task automatic configure(int phase);
      int v [8];
      case (phase)
         0: v = '{13107, 1536, 13107, 1638, 3277, 2621, 500, 50};
         1: v = '{32767, 4095, 32767, 32767, 65535, 32767, 65535, 255};
         2: v = '{0, 0, 0, 0, 0, 0, 0, 1};
         3: v = '{$urandom_range(32767), $urandom_range(4095), $urandom_range(32767),
                  $urandom_range(3000), $urandom_range(65535), $urandom_range(32767),
                  $urandom_range(20), $urandom_range(255, 1)};
         default: v = '{20000, 2000, 30000, $urandom_range(500), 65535, 32767, 3, 1};
      endcase
      for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), v[i]);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (velocity_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_beat(req_type r, bit known, rsp_type k);
      rsp_type p;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(12, 1);
      end
      req_ch.data <= r;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      p = predict_velocity(r);
      velocity_q.push_back(known ? k : p);
   endtask

   function automatic req_type make_item(bit nt, bit tidy);
      req_type r;
      r.new_target = nt;
      r.yaw_rate = 16'($urandom);
      if (!tidy) begin
         r.goal_x = $urandom; r.goal_y = $urandom;
         r.gaze_x = $urandom; r.gaze_y = $urandom;
         r.pos_x = $urandom; r.pos_y = $urandom;
         r.quat_z = 16'($signed($urandom_range(32768)) - 16384);
         r.quat_w = 16'($signed($urandom_range(32768)) - 16384);
      end else begin
         r.pos_x = $signed($urandom_range(2097152)) - 1048576;
         r.pos_y = $signed($urandom_range(2097152)) - 1048576;
         r.goal_x = r.pos_x + $signed($urandom_range(16000)) - 8000;
         r.goal_y = r.pos_y + $signed($urandom_range(16000)) - 8000;
         r.gaze_x = r.pos_x + 32'd1000000;
         r.gaze_y = r.pos_y + $signed($urandom_range(2000)) - 1000;
         r.quat_z = 16'($signed($urandom_range(200)) - 100);
         r.quat_w = 16'sd16384;
         if ($urandom_range(3) == 0) r.yaw_rate = 16'($signed($urandom_range(200)) - 100);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_random <= ~stall_random;
         stall_left <= $urandom_range(200, 20);
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_ch.ready <= stall_random ? ($urandom_range(2) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (velocity_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_ch.data);
         end else begin
            want = velocity_q.pop_front();
            if (rsp_ch.data.cmd_valid !== want.cmd_valid || rsp_ch.data.vel_x !== want.vel_x
                || rsp_ch.data.vel_y !== want.vel_y || rsp_ch.data.vel_yaw !== want.vel_yaw
                || rsp_ch.data.dist_twice !== want.dist_twice
                || rsp_ch.data.mode !== want.mode) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_ch.data);
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      rsp_type zero_idle;
      int per_phase, left;
      bit tidy;
      cycles = 0; mismatches = 0; burst_left = 4; stall_left = 0; stall_random = 0;
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_data = '0;
      req_ch.valid = 1'b0; req_ch.data = '0; rsp_ch.ready = 1'b0;
      speed_lim = 13107; gain = 1536; yaw_lim = 13107; deadband = 1638;
      arr_dist = 3277; arr_yaw = 2621; hold_lim = 500; smooth = 50;
      run_state = MODE_IDLE; arrived = 0; hold_cnt = 0; prev_vx = 0; prev_vy = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      zero_idle = '0;
      zero_idle.mode = MODE_IDLE;
      row.data = '0; row.known = 1; row.rsp = zero_idle;
      rows.push_back(row);
      row.known = 0;
      row.data = '{1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh8000_0000, 32'sh8000_0000, 16'sd16384, 16'sd16384, 16'sh7FFF};
      rows.push_back(row);
      row.data = '{1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sd16384, 16'sd16384, 16'sh8000};
      rows.push_back(row);
      // goal at robot, gaze at robot
      row.data = '{1'b0, 32'sd5000, -32'sd7, 32'sd5000, -32'sd7, 32'sd5000, -32'sd7,
                   16'sd0, 16'sd0, 16'sd0};
      rows.push_back(row);
      // gaze straight behind: half-turn error
      row.data = '{1'b0, 32'sd65536, 32'sd0, -32'sd65536, 32'sd0, 32'sd0, 32'sd0,
                   16'sd0, 16'sd16384, 16'sd0};
      rows.push_back(row);
      row.data = '{1'b1, -32'sd131072, 32'sd65536, 32'sd0, 32'sd100000, 32'sd0, 32'sd0,
                   16'sd11585, 16'sd11585, -16'sd4096};
      rows.push_back(row);
      row.data = '{1'b0, 32'sd10, 32'sd0, 32'sd1000000, 32'sd0, 32'sd0, 32'sd0,
                   16'sd0, -16'sd16384, 16'sd1};
      rows.push_back(row);
      row.data = '{1'b0, 32'sd0, 32'sd0, 32'sd1000000, 32'sd0, 32'sd0, 32'sd0,
                   -16'sd16384, 16'sd0, 16'sd0};
      rows.push_back(row);
      for (int i = 0; i < rows.size(); i++) send_beat(rows[i].data, rows[i].known, rows[i].rsp);
      req_ch.valid <= 1'b0;
      drain();

      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         configure(ph);
         left = per_phase;
         while (left > 0) begin
            tidy = $urandom_range(4) != 0;
            send_beat(make_item(1'b1, tidy), 0, '0);
            left--;
            for (int k = $urandom_range(40, 3); k > 0 && left > 0; k--) begin
               send_beat(make_item($urandom_range(15) == 0, tidy && $urandom_range(9) != 0),
                         0, '0);
               left--;
            end
         end
         req_ch.valid <= 1'b0;
         drain();
      end

      if (mismatches == 0 && velocity_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
